// ----- rtl/core/v2d_pkg.sv -----
// Shared types, pipeline schedule and cosine tables for the 2D vector unit.
// No dependencies; used by vector2d_magnitude_normalize_dot.
`default_nettype none
package v2d_pkg;

    typedef enum logic [1:0] {
        FUNC_MAG  = 2'd0,
        FUNC_NORM = 2'd1,
        FUNC_DOT  = 2'd2
    } func_e;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [8:0]         angle_degrees;
    } item_t;

    typedef struct packed {
        logic signed [23:0] scalar_value;
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic               zero_vector;
        logic               saturated;
    } result_t;

    localparam int NUM_STAGES = 26;
    localparam int STG_SUM    = 1;
    localparam int STG_DIV    = 2;
    localparam int STG_DIV_LAST = 17;
    localparam int STG_MAG    = 10;
    localparam int STG_MUL1   = 11;
    localparam int STG_MUL2   = 12;
    localparam int STG_DOT    = 13;
    localparam int STG_ROOT   = 18;
    localparam int DIV_STEPS  = 31;
    localparam int SQRT_STEPS = 16;

    localparam longint unsigned Q28_ONE    = 64'd268435456;
    localparam longint unsigned Q28_PI     = 64'd843314857;
    localparam longint unsigned Q28_TWO_PI = 64'd1686629714;

    typedef logic signed [15:0] cos_half_t [256];

    function automatic logic signed [15:0] cos_q14(input longint unsigned deg);
        longint unsigned th;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned p;
        longint          c;
        longint unsigned r;
        logic            neg;
        th = (deg * 64'd7 * Q28_ONE + 64'd200) / 64'd400;
        neg = 1'b0;
        if (th >= Q28_TWO_PI)
            th = th - Q28_TWO_PI;
        if (th > Q28_PI)
            th = Q28_TWO_PI - th;
        if (th > Q28_PI / 2)
        begin
            neg = 1'b1;
            x = Q28_PI - th;
        end
        else
        begin
            x = th;
        end
        x2 = (x * x) >> 28;
        t = Q28_ONE - ((x2 * Q28_ONE) >> 28) / 64'd90;
        t = Q28_ONE - ((x2 * t) >> 28) / 64'd56;
        t = Q28_ONE - ((x2 * t) >> 28) / 64'd30;
        t = Q28_ONE - ((x2 * t) >> 28) / 64'd12;
        p = ((x2 * t) >> 28) / 64'd2;
        c = longint'(Q28_ONE) - longint'(p);
        if (c < 0)
            c = 0;
        r = (longint'(c) + 64'd8192) >> 14;
        return neg ? -16'(r) : 16'(r);
    endfunction

    function automatic cos_half_t cos_half(input longint unsigned base);
        cos_half_t tab;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = cos_q14(base + longint'(i));
        end
        return tab;
    endfunction

    localparam cos_half_t COS_LO = cos_half(64'd0);
    localparam cos_half_t COS_HI = cos_half(64'd256);

endpackage
`default_nettype wire

// ----- rtl/core/vector2d_magnitude_normalize_dot.sv -----
// 2D vector unit: magnitude, normalize and dot product by angle.
// Depends on v2d_pkg for payload types, stage schedule and cosine tables.
//
// Usage:
//   Input channel item/item_valid/item_stall carries one v2d_pkg::item_t per
//   transfer; output channel result/result_valid/result_stall carries one
//   v2d_pkg::result_t. Every input transfer yields exactly one result.
//   Throughput is one item per cycle while the output is not held: the
//   26-stage pipeline holds one item per stage. Depth is set by the 31-step
//   restoring divider (two steps per stage) followed by the 16-step square
//   root of the normalize path.
//   When result_valid is high and result_stall is high the whole pipeline
//   holds and item_stall goes high; nothing is lost or repeated.
//   Reset (rst_n low, asynchronous) clears all valid bits; the pipeline is
//   empty and ready to take items once reset is released.
`default_nettype none
module vector2d_magnitude_normalize_dot
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire v2d_pkg::item_t   item,
    input  wire                   item_valid,
    output logic                  item_stall,
    output v2d_pkg::result_t      result,
    output logic                  result_valid,
    input  wire                   result_stall
);

    typedef struct packed {
        logic [31:0] v;
        logic [31:0] r;
    } sqs_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] q;
    } dvs_t;

    typedef struct packed {
        logic [1:0]         func;
        logic               neg_x;
        logic               neg_y;
        logic signed [15:0] cosv;
        logic [30:0]        ax2;
        logic [30:0]        ay2;
        logic [30:0]        bx2;
        logic [30:0]        by2;
        logic [31:0]        sa;
        logic [31:0]        sb;
        sqs_t               rta;
        sqs_t               rtb;
        dvs_t               dvx;
        dvs_t               dvy;
        sqs_t               rtx;
        sqs_t               rty;
        logic [15:0]        ma;
        logic [15:0]        mb;
        logic [46:0]        prod;
        logic [23:0]        dot;
        logic               sat;
    } st_t;

    function automatic sqs_t sq_step(input sqs_t a, input int n);
        logic [31:0] b;
        logic [32:0] t;
        sqs_t        o;
        b = 32'd1 << (30 - 2 * n);
        t = {1'b0, a.r} + {1'b0, b};
        if ({1'b0, a.v} >= t)
        begin
            o.v = a.v - t[31:0];
            o.r = (a.r >> 1) + b;
        end
        else
        begin
            o.v = a.v;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

    function automatic dvs_t dv_step(input dvs_t a, input logic [31:0] d, input logic nb);
        logic [32:0] r2;
        dvs_t        o;
        r2 = {a.rem, nb};
        if (r2 >= {1'b0, d})
        begin
            o.rem = 32'(r2 - {1'b0, d});
            o.q   = {a.q[29:0], 1'b1};
        end
        else
        begin
            o.rem = r2[31:0];
            o.q   = {a.q[29:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    function automatic st_t entry(input v2d_pkg::item_t it);
        st_t         o;
        logic [15:0] a;
        o = '0;
        o.func  = it.func;
        o.neg_x = it.ax[15];
        o.neg_y = it.ay[15];
        o.cosv  = it.angle_degrees[8] ? v2d_pkg::COS_HI[it.angle_degrees[7:0]]
                                      : v2d_pkg::COS_LO[it.angle_degrees[7:0]];
        a = abs16(it.ax);
        o.ax2 = 31'(32'(a) * 32'(a));
        a = abs16(it.ay);
        o.ay2 = 31'(32'(a) * 32'(a));
        a = abs16(it.bx);
        o.bx2 = 31'(32'(a) * 32'(a));
        a = abs16(it.by);
        o.by2 = 31'(32'(a) * 32'(a));
        return o;
    endfunction

    function automatic st_t advance(input st_t s, input int k);
        st_t         o;
        int          n;
        logic [14:0] cabs;
        logic [47:0] rs;
        logic [25:0] rnd;
        o = s;
        if (k == v2d_pkg::STG_SUM)
        begin
            o.sa = {1'b0, s.ax2} + {1'b0, s.ay2};
            o.sb = {1'b0, s.bx2} + {1'b0, s.by2};
            o.rta.v = o.sa;
            o.rta.r = '0;
            o.rtb.v = o.sb;
            o.rtb.r = '0;
            o.dvx.rem = {2'b00, s.ax2[30:1]};
            o.dvx.q   = '0;
            o.dvy.rem = {2'b00, s.ay2[30:1]};
            o.dvy.q   = '0;
        end
        if (k >= v2d_pkg::STG_DIV && k <= v2d_pkg::STG_DIV_LAST)
        begin
            for (int j = 0; j < 2; j++)
            begin
                n = 2 * (k - v2d_pkg::STG_DIV) + j;
                if (n < v2d_pkg::DIV_STEPS)
                begin
                    o.dvx = dv_step(o.dvx, s.sa, (n == 0) ? s.ax2[0] : 1'b0);
                    o.dvy = dv_step(o.dvy, s.sa, (n == 0) ? s.ay2[0] : 1'b0);
                end
                if (n < v2d_pkg::SQRT_STEPS)
                begin
                    o.rta = sq_step(o.rta, n);
                    o.rtb = sq_step(o.rtb, n);
                end
            end
        end
        if (k == v2d_pkg::STG_MAG)
        begin
            o.ma = (s.rta.v > s.rta.r) ? 16'(s.rta.r + 32'd1) : s.rta.r[15:0];
            o.mb = (s.rtb.v > s.rtb.r) ? 16'(s.rtb.r + 32'd1) : s.rtb.r[15:0];
        end
        if (k == v2d_pkg::STG_MUL1)
            o.prod = 47'(32'(s.ma) * 32'(s.mb));
        if (k == v2d_pkg::STG_MUL2)
        begin
            cabs = s.cosv[15] ? 15'(-s.cosv) : s.cosv[14:0];
            o.prod = 47'(s.prod[31:0]) * 47'(cabs);
        end
        if (k == v2d_pkg::STG_DOT)
        begin
            rs  = {1'b0, s.prod} + 48'(1 << 21);
            rnd = rs[47:22];
            if (s.cosv[15])
            begin
                o.sat = rnd > 26'd8388608;
                o.dot = o.sat ? 24'h800000 : 24'(-rnd);
            end
            else
            begin
                o.sat = rnd > 26'd8388607;
                o.dot = o.sat ? 24'h7FFFFF : rnd[23:0];
            end
        end
        if (k >= v2d_pkg::STG_ROOT)
        begin
            if (k == v2d_pkg::STG_ROOT)
            begin
                o.rtx.v = {1'b0, s.dvx.q};
                o.rtx.r = '0;
                o.rty.v = {1'b0, s.dvy.q};
                o.rty.r = '0;
            end
            for (int j = 0; j < 2; j++)
            begin
                n = 2 * (k - v2d_pkg::STG_ROOT) + j;
                if (n < v2d_pkg::SQRT_STEPS)
                begin
                    o.rtx = sq_step(o.rtx, n);
                    o.rty = sq_step(o.rty, n);
                end
            end
        end
        return o;
    endfunction

    function automatic v2d_pkg::result_t finish(input st_t s);
        v2d_pkg::result_t o;
        logic [16:0]      ux;
        logic [16:0]      uy;
        o = '0;
        ux = (17'(s.rtx.r[15:0]) + 17'd1) >> 1;
        uy = (17'(s.rty.r[15:0]) + 17'd1) >> 1;
        case (s.func)
            v2d_pkg::FUNC_MAG:
                o.scalar_value = 24'(s.ma);
            v2d_pkg::FUNC_NORM:
            begin
                if (s.sa == '0)
                begin
                    o.zero_vector = 1'b1;
                end
                else
                begin
                    o.unit_x = s.neg_x ? -16'(ux) : 16'(ux);
                    o.unit_y = s.neg_y ? -16'(uy) : 16'(uy);
                end
            end
            v2d_pkg::FUNC_DOT:
            begin
                o.scalar_value = s.dot;
                o.saturated    = s.sat;
            end
            default:
                o = '0;
        endcase
        return o;
    endfunction

    st_t              stage_reg [v2d_pkg::NUM_STAGES];
    logic             valid_reg [v2d_pkg::NUM_STAGES];
    v2d_pkg::result_t result_reg;
    logic             result_valid_reg;
    logic             advance_en;

    assign advance_en   = !(result_valid_reg && result_stall);
    assign item_stall   = !advance_en;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < v2d_pkg::NUM_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            result_valid_reg <= 1'b0;
        end
        else if (advance_en)
        begin
            valid_reg[0] <= item_valid;
            for (int k = 1; k < v2d_pkg::NUM_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            result_valid_reg <= valid_reg[v2d_pkg::NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance_en)
        begin
            stage_reg[0] <= entry(item);
            for (int k = 1; k < v2d_pkg::NUM_STAGES; k++)
            begin
                stage_reg[k] <= advance(stage_reg[k-1], k);
            end
            result_reg <= finish(stage_reg[v2d_pkg::NUM_STAGES-1]);
        end
    end

`ifndef SYNTHESIS
    a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("input stall does not follow output hold");

    a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.zero_vector) |->
            (result.unit_x == 16'sd0 && result.unit_y == 16'sd0 &&
             result.scalar_value == 24'sd0))
        else $error("zero vector result carries non-zero fields");

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |->
            (result.scalar_value == 24'sh7FFFFF || result.scalar_value == 24'sh800000))
        else $error("saturated flag without clipped value");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result.unit_x <= 16'sd16384 && result.unit_x >= -16'sd16384 &&
             result.unit_y <= 16'sd16384 && result.unit_y >= -16'sd16384))
        else $error("unit component out of range");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(result_reg))
        else $error("result register changed under hold");
`endif

endmodule
`default_nettype wire
